[sv/html_paragraph_text_extractor_defines.svh]
// Assertion macros for the paragraph text extractor checkers.
`ifndef HTML_PARAGRAPH_TEXT_EXTRACTOR_DEFINES_SVH
`define HTML_PARAGRAPH_TEXT_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HPTE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HPTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication that is checked through reset as well.
`define HPTE_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

[sv/hpte_pkg.sv]
// ----------------------------------------------------------------------------
// hpte_pkg
// Types and constants shared by the HTML paragraph text extractor.
// ----------------------------------------------------------------------------
package hpte_pkg;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       doc_last;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       keep;
      logic       doc_end;
   } rsp_item_type;

   localparam logic [1:0] MODE_OUTSIDE   = 2'd0;
   localparam logic [1:0] MODE_OPEN_TAG  = 2'd1;
   localparam logic [1:0] MODE_CONTENT   = 2'd2;
   localparam logic [1:0] MODE_INNER_TAG = 2'd3;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_P     = 8'h70;

   // Progress through the "</p" close sequence.
   localparam logic [1:0] CLOSE_NONE  = 2'd0;
   localparam logic [1:0] CLOSE_LT    = 2'd1;
   localparam logic [1:0] CLOSE_SLASH = 2'd2;

   localparam logic [1:0] TAG_POS_MAX = 2'd3;
   localparam logic [1:0] TAG_POS_P   = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic       saw_lt;
      logic [1:0] close_prog;
      logic       close_in_tag;
      logic [1:0] tag_pos;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      mode: MODE_OUTSIDE, saw_lt: 1'b0, close_prog: CLOSE_NONE,
      close_in_tag: 1'b0, tag_pos: 2'd0};

endpackage

[sv/hpte_scan.sv]
// ----------------------------------------------------------------------------
// hpte_scan
// Paragraph scanner: state registers and the per-byte classify/update logic.
// ----------------------------------------------------------------------------
module hpte_scan
   import hpte_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_item_type item,
   output rsp_item_type result
);

   scan_state_type state_ff, state_in, next_st;
   logic           keep;
   logic [1:0]     pos;

   always_comb begin
      next_st = state_ff;
      keep    = 1'b0;
      pos     = (state_ff.tag_pos < TAG_POS_MAX) ? state_ff.tag_pos + 2'd1 : TAG_POS_MAX;
      unique case (state_ff.mode)
         MODE_OUTSIDE: begin
            if (state_ff.saw_lt && item.text_byte == CH_P) begin
               next_st.mode   = MODE_OPEN_TAG;
               next_st.saw_lt = 1'b0;
            end else begin
               next_st.saw_lt = (item.text_byte == CH_LT);
            end
         end
         MODE_OPEN_TAG: begin
            if (item.text_byte == CH_GT) next_st.mode = MODE_CONTENT;
         end
         MODE_CONTENT: begin
            if (item.text_byte == CH_LT) begin
               next_st.mode         = MODE_INNER_TAG;
               next_st.tag_pos      = 2'd0;
               next_st.close_prog   = CLOSE_LT;
               next_st.close_in_tag = 1'b0;
            end else begin
               keep = 1'b1;
            end
         end
         MODE_INNER_TAG: begin
            next_st.tag_pos = pos;
            if (item.text_byte == CH_GT) begin
               next_st.mode         = state_ff.close_in_tag ? MODE_OUTSIDE : MODE_CONTENT;
               next_st.close_prog   = CLOSE_NONE;
               next_st.close_in_tag = 1'b0;
               next_st.tag_pos      = 2'd0;
               next_st.saw_lt       = 1'b0;
            end else if (item.text_byte == CH_LT) begin
               next_st.close_prog = CLOSE_LT;
            end else if (item.text_byte == CH_SLASH && state_ff.close_prog == CLOSE_LT) begin
               next_st.close_prog = CLOSE_SLASH;
            end else if (item.text_byte == CH_P && state_ff.close_prog == CLOSE_SLASH) begin
               next_st.close_prog = CLOSE_NONE;
               if (pos == TAG_POS_P) begin
                  // close tag at tag start: paragraph ends right after the 'p'
                  next_st.mode         = MODE_OUTSIDE;
                  next_st.saw_lt       = 1'b0;
                  next_st.close_in_tag = 1'b0;
                  next_st.tag_pos      = 2'd0;
               end else begin
                  next_st.close_in_tag = 1'b1;
               end
            end else begin
               next_st.close_prog = CLOSE_NONE;
            end
         end
         default: next_st = state_ff;
      endcase
   end

   assign state_in = item.doc_last ? SCAN_RESET : next_st;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign result.out_byte = item.text_byte;
   assign result.keep     = keep;
   assign result.doc_end  = item.doc_last;

endmodule

[sv/html_paragraph_text_extractor.sv]
// ----------------------------------------------------------------------------
// html_paragraph_text_extractor
// Byte stream filter that flags the text bytes of HTML paragraphs.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one document byte per transaction with doc_last on the
//   final byte; rsp_* returns one result per byte, in order: the byte, a
//   keep flag for paragraph text, and doc_end echoing doc_last.
//   The byte is held in an input register; the scanner classifies it and
//   updates its state as it moves into the result register.
//   Throughput: one byte per cycle while rsp_ready stays high; the only
//   loop is the scanner state update.
//   Reset (synchronous) empties both registers and returns the scanner to
//   the outside-paragraph state; the byte flagged doc_last does the same
//   for the scanner after it is processed.
//   When the receiver stalls, the result register holds, the input register
//   still takes one more byte, and then req_ready drops until rsp_ready
//   returns.
// ----------------------------------------------------------------------------
module html_paragraph_text_extractor
   import hpte_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type scan_result;
   logic         out_load;
   logic         in_load;

   assign out_load    = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || out_load;
   assign in_load     = req_valid && req_ready;
   assign in_valid_in = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_ready);

   hpte_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (out_load),
      .item    (in_item_ff),
      .result  (scan_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) in_item_ff <= req_data;
      if (out_load) out_item_ff <= scan_result;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

endmodule

[sv/hpte_checker.sv]
// ----------------------------------------------------------------------------
// hpte_checker
// Port-level checks for the paragraph text extractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "html_paragraph_text_extractor_defines.svh"

module hpte_checker
   import hpte_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_item_type req_data,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_data
);

   // a stalled result holds
   `HPTE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // the result register is empty right after reset
   `HPTE_ASSERT_ALWAYS(a_rsp_reset, clock, $past(reset), !rsp_valid, "result valid after reset")

   // a tag opener is never paragraph text
   `HPTE_ASSERT_SAME(a_lt_dropped, clock, reset, rsp_valid && rsp_data.keep, rsp_data.out_byte != CH_LT, "kept a '<' byte")

   // a new document starts outside any paragraph
   `HPTE_ASSERT_NEXT(a_doc_restart, clock, reset, rsp_valid && rsp_ready && rsp_data.doc_end, !(rsp_valid && rsp_data.keep), "first byte of document kept")

endmodule

bind html_paragraph_text_extractor hpte_checker u_hpte_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
